/* rtl/tsac_pkg.sv */
// Shared types and constants for the touch sample averager.
package tsac_pkg;

    localparam int unsigned RAW_W = 16;
    localparam int unsigned CFG_W = 6;
    localparam int unsigned STEP_W = 3;

    localparam logic [RAW_W-1:0]  RAW_INVALID_LO = 16'h0000;
    localparam logic [RAW_W-1:0]  RAW_INVALID_HI = 16'hFFFF;
    localparam logic [CFG_W-1:0]  MIN_SAMPLES_RESET = 6'd6;
    localparam logic [STEP_W-1:0] STEP_FIRST = 3'd0;
    localparam logic [STEP_W-1:0] STEP_DONE = 3'd4;

    typedef enum logic [1:0] {
        OP_SAMPLE  = 2'd0,
        OP_TICK    = 2'd1,
        OP_START   = 2'd2,
        OP_ADVANCE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_POINT  = 2'd0,
        KIND_STEP   = 2'd1,
        KIND_CORNER = 2'd2,
        KIND_FINISH = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_AVG,
        ST_EMIT_AVG,
        ST_DIV_CAL,
        ST_EMIT_CORNER,
        ST_EMIT_STEP,
        ST_EMIT_FINISH
    } back_state_t;

    typedef struct packed {
        op_t             op;
        logic [RAW_W-1:0] x;
        logic [RAW_W-1:0] y;
    } cmd_t;

    typedef struct packed {
        kind_t             kind;
        logic [STEP_W-1:0] cal_step;
        logic [RAW_W-1:0]  avg_x;
        logic [RAW_W-1:0]  avg_y;
        logic [RAW_W-1:0]  bound_x_low;
        logic [RAW_W-1:0]  bound_y_low;
        logic [RAW_W-1:0]  bound_x_high;
        logic [RAW_W-1:0]  bound_y_high;
        logic              last;
    } result_t;

endpackage

/* rtl/tsac_front.sv */
// Front end: accepts input beats, drops invalid samples, rotates valid ones.
module tsac_front
    import tsac_pkg::*;
#(
    parameter int unsigned ADC_MAX = 4095
)
(
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic [2:0]  s_axis_tuser,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_cmd
);

    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
    logic             released;
    op_t              op;
    logic             sample_ok;
    logic             keep;

    assign raw_x    = s_axis_tdata[15:0];
    assign raw_y    = s_axis_tdata[31:16];
    assign op       = op_t'(s_axis_tuser[1:0]);
    assign released = s_axis_tuser[2];

    assign sample_ok = !released
                       && (raw_x != RAW_INVALID_LO) && (raw_x != RAW_INVALID_HI)
                       && (raw_y != RAW_INVALID_LO) && (raw_y != RAW_INVALID_HI);

    assign keep          = (op != OP_SAMPLE) || sample_ok;
    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full && keep;

    always_comb
    begin
        q_cmd.op = op;
        q_cmd.x  = RAW_W'(ADC_MAX) - raw_y;
        q_cmd.y  = raw_x;
    end

endmodule

/* rtl/tsac_queue.sv */
// Two-entry command queue between front end and back end.
module tsac_queue
    import tsac_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic valid,
    output cmd_t pop_cmd
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_pop;

    assign full    = (count_reg == 2'd2);
    assign valid   = (count_reg != 2'd0);
    assign pop_cmd = entry_reg[rd_ptr_reg];
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/tsac_divider.sv */
// Restoring divider, one quotient bit per cycle.
module tsac_divider #(
    parameter int unsigned DVD_W = 22,
    parameter int unsigned DSR_W = 7
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int unsigned CNT_W = $clog2(DVD_W);

    logic             busy_reg;
    logic             busy_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [DSR_W-1:0] rem_reg;
    logic [DSR_W-1:0] rem_next;
    logic [DVD_W-1:0] quo_reg;
    logic [DVD_W-1:0] quo_next;
    logic [DSR_W-1:0] dsr_reg;
    logic [DSR_W-1:0] dsr_next;
    logic [DSR_W:0]   shifted;
    logic [DSR_W:0]   diff;
    logic             ge;
    logic             last_bit;

    assign shifted  = {rem_reg, quo_reg[DVD_W-1]};
    assign diff     = shifted - {1'b0, dsr_reg};
    assign ge       = (shifted >= {1'b0, dsr_reg});
    assign last_bit = (cnt_reg == CNT_W'(DVD_W - 1));
    assign done     = busy_reg && last_bit;
    assign quotient = quo_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
            quo_next  = {quo_reg[DVD_W-2:0], ge};
            cnt_next  = cnt_reg + CNT_W'(1);
            busy_next = !last_bit;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

/* rtl/tsac_back.sv */
// Back end: sample window, averaging, calibration sequencer and result register.
module tsac_back
    import tsac_pkg::*;
#(
    parameter int unsigned MAX_SAMPLES = 32,
    parameter int unsigned CAL_SAMPLES = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             q_valid,
    input  cmd_t             q_cmd,
    output logic             q_pop,
    output logic             res_valid,
    input  logic             res_ready,
    output result_t          res
);

    localparam int unsigned COUNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned CCNT_W  = $clog2(CAL_SAMPLES + 1);
    localparam int unsigned SUM_W   = RAW_W + COUNT_W;
    localparam int unsigned CSUM_W  = RAW_W + CCNT_W;
    localparam int unsigned DVD_W   = (SUM_W > CSUM_W) ? SUM_W : CSUM_W;
    localparam int unsigned DSR_W   = (COUNT_W > CCNT_W) ? COUNT_W : CCNT_W;
    localparam int unsigned CMP_W   = (COUNT_W > CFG_W) ? COUNT_W : CFG_W;

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [CFG_W-1:0]  min_samples_reg;
    logic [CFG_W-1:0]  min_samples_next;
    logic [COUNT_W-1:0] win_count_reg;
    logic [COUNT_W-1:0] win_count_next;
    logic [SUM_W-1:0]  win_sum_x_reg;
    logic [SUM_W-1:0]  win_sum_x_next;
    logic [SUM_W-1:0]  win_sum_y_reg;
    logic [SUM_W-1:0]  win_sum_y_next;
    logic              calibrating_reg;
    logic              calibrating_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [CCNT_W-1:0] cal_count_reg;
    logic [CCNT_W-1:0] cal_count_next;
    logic [CSUM_W-1:0] cal_sum_x_reg;
    logic [CSUM_W-1:0] cal_sum_x_next;
    logic [CSUM_W-1:0] cal_sum_y_reg;
    logic [CSUM_W-1:0] cal_sum_y_next;
    logic [RAW_W-1:0]  corner_x_reg [4];
    logic [RAW_W-1:0]  corner_x_next [4];
    logic [RAW_W-1:0]  corner_y_reg [4];
    logic [RAW_W-1:0]  corner_y_next [4];
    logic              res_valid_reg;
    logic              res_valid_next;
    result_t           res_reg;
    result_t           res_next;

    logic              out_free;
    logic [CMP_W-1:0]  need;
    logic              window_short;
    logic              window_full;
    logic [CCNT_W-1:0] cal_count_inc;
    logic              cal_full;
    logic [CSUM_W-1:0] cal_sum_x_inc;
    logic [CSUM_W-1:0] cal_sum_y_inc;
    logic              div_start;
    logic [DVD_W-1:0]  div_dvd_x;
    logic [DVD_W-1:0]  div_dvd_y;
    logic [DSR_W-1:0]  div_dsr;
    logic              div_done_x;
    logic              div_done_y;
    logic [DVD_W-1:0]  quo_x;
    logic [DVD_W-1:0]  quo_y;
    logic [RAW_W-1:0]  avg_x;
    logic [RAW_W-1:0]  avg_y;
    logic [RAW_W:0]    sum_xl;
    logic [RAW_W:0]    sum_yl;
    logic [RAW_W:0]    sum_xh;
    logic [RAW_W:0]    sum_yh;

    tsac_divider #(
        .DVD_W (DVD_W),
        .DSR_W (DSR_W)
    ) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd_x),
        .divisor  (div_dsr),
        .done     (div_done_x),
        .quotient (quo_x)
    );

    tsac_divider #(
        .DVD_W (DVD_W),
        .DSR_W (DSR_W)
    ) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd_y),
        .divisor  (div_dsr),
        .done     (div_done_y),
        .quotient (quo_y)
    );

    assign out_free      = !res_valid_reg || res_ready;
    assign need          = (min_samples_reg == '0) ? CMP_W'(1) : CMP_W'(min_samples_reg);
    assign window_short  = (CMP_W'(win_count_reg) < need);
    assign window_full   = (win_count_reg >= COUNT_W'(MAX_SAMPLES));
    assign cal_count_inc = cal_count_reg + CCNT_W'(1);
    assign cal_full      = calibrating_reg && (cal_count_inc >= CCNT_W'(CAL_SAMPLES));
    assign avg_x         = quo_x[RAW_W-1:0];
    assign avg_y         = quo_y[RAW_W-1:0];
    assign cal_sum_x_inc = cal_sum_x_reg + CSUM_W'(avg_x);
    assign cal_sum_y_inc = cal_sum_y_reg + CSUM_W'(avg_y);
    assign sum_xl        = {1'b0, corner_x_reg[0]} + {1'b0, corner_x_reg[2]};
    assign sum_yl        = {1'b0, corner_y_reg[0]} + {1'b0, corner_y_reg[1]};
    assign sum_xh        = {1'b0, corner_x_reg[1]} + {1'b0, corner_x_reg[3]};
    assign sum_yh        = {1'b0, corner_y_reg[2]} + {1'b0, corner_y_reg[3]};
    assign res_valid     = res_valid_reg;
    assign res           = res_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_cmd.op)
                        OP_SAMPLE:  state_next = ST_IDLE;
                        OP_TICK:    state_next = window_short ? ST_IDLE : ST_DIV_AVG;
                        OP_START:   state_next = ST_EMIT_STEP;
                        OP_ADVANCE: state_next = calibrating_reg ? ST_EMIT_STEP : ST_IDLE;
                    endcase
                end
            end
            ST_DIV_AVG:
            begin
                if (div_done_x)
                begin
                    state_next = ST_EMIT_AVG;
                end
            end
            ST_EMIT_AVG:
            begin
                if (out_free)
                begin
                    state_next = cal_full ? ST_DIV_CAL : ST_IDLE;
                end
            end
            ST_DIV_CAL:
            begin
                if (div_done_y)
                begin
                    state_next = ST_EMIT_CORNER;
                end
            end
            ST_EMIT_CORNER:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_STEP:
            begin
                if (out_free)
                begin
                    state_next = (step_reg == STEP_DONE) ? ST_EMIT_FINISH : ST_IDLE;
                end
            end
            ST_EMIT_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        min_samples_next = cfg_we ? cfg_wdata : min_samples_reg;
        win_count_next   = win_count_reg;
        win_sum_x_next   = win_sum_x_reg;
        win_sum_y_next   = win_sum_y_reg;
        calibrating_next = calibrating_reg;
        step_next        = step_reg;
        cal_count_next   = cal_count_reg;
        cal_sum_x_next   = cal_sum_x_reg;
        cal_sum_y_next   = cal_sum_y_reg;
        corner_x_next    = corner_x_reg;
        corner_y_next    = corner_y_reg;
        res_valid_next   = res_valid_reg && !res_ready;
        res_next         = res_reg;
        q_pop            = 1'b0;
        div_start        = 1'b0;
        div_dvd_x        = DVD_W'(win_sum_x_reg);
        div_dvd_y        = DVD_W'(win_sum_y_reg);
        div_dsr          = DSR_W'(win_count_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    unique case (q_cmd.op)
                        OP_SAMPLE:
                        begin
                            if (!window_full)
                            begin
                                win_sum_x_next = win_sum_x_reg + SUM_W'(q_cmd.x);
                                win_sum_y_next = win_sum_y_reg + SUM_W'(q_cmd.y);
                                win_count_next = win_count_reg + COUNT_W'(1);
                            end
                        end
                        OP_TICK:
                        begin
                            div_start      = !window_short;
                            win_count_next = '0;
                            win_sum_x_next = '0;
                            win_sum_y_next = '0;
                        end
                        OP_START:
                        begin
                            step_next        = STEP_FIRST;
                            calibrating_next = 1'b1;
                            cal_count_next   = '0;
                            cal_sum_x_next   = '0;
                            cal_sum_y_next   = '0;
                            for (int i = 0; i < 4; i++)
                            begin
                                corner_x_next[i] = '0;
                                corner_y_next[i] = '0;
                            end
                        end
                        OP_ADVANCE:
                        begin
                            if (calibrating_reg)
                            begin
                                step_next = step_reg + STEP_W'(1);
                            end
                        end
                    endcase
                end
            end
            ST_EMIT_AVG:
            begin
                if (out_free)
                begin
                    res_valid_next        = 1'b1;
                    res_next              = '0;
                    res_next.kind         = KIND_POINT;
                    res_next.cal_step     = step_reg;
                    res_next.avg_x        = avg_x;
                    res_next.avg_y        = avg_y;
                    res_next.last         = !cal_full;
                    if (cal_full)
                    begin
                        div_start      = 1'b1;
                        div_dvd_x      = DVD_W'(cal_sum_x_inc);
                        div_dvd_y      = DVD_W'(cal_sum_y_inc);
                        div_dsr        = DSR_W'(CAL_SAMPLES);
                        cal_count_next = '0;
                        cal_sum_x_next = '0;
                        cal_sum_y_next = '0;
                    end
                    else if (calibrating_reg)
                    begin
                        cal_count_next = cal_count_inc;
                        cal_sum_x_next = cal_sum_x_inc;
                        cal_sum_y_next = cal_sum_y_inc;
                    end
                end
            end
            ST_EMIT_CORNER:
            begin
                if (out_free)
                begin
                    corner_x_next[step_reg[1:0]] = avg_x;
                    corner_y_next[step_reg[1:0]] = avg_y;
                    res_valid_next    = 1'b1;
                    res_next          = '0;
                    res_next.kind     = KIND_CORNER;
                    res_next.cal_step = step_reg;
                    res_next.avg_x    = avg_x;
                    res_next.avg_y    = avg_y;
                    res_next.last     = 1'b1;
                end
            end
            ST_EMIT_STEP:
            begin
                if (out_free)
                begin
                    res_valid_next    = 1'b1;
                    res_next          = '0;
                    res_next.kind     = KIND_STEP;
                    res_next.cal_step = step_reg;
                    res_next.last     = (step_reg != STEP_DONE);
                end
            end
            ST_EMIT_FINISH:
            begin
                if (out_free)
                begin
                    res_valid_next        = 1'b1;
                    res_next              = '0;
                    res_next.kind         = KIND_FINISH;
                    res_next.cal_step     = STEP_DONE;
                    res_next.bound_x_low  = sum_xl[RAW_W:1];
                    res_next.bound_y_low  = sum_yl[RAW_W:1];
                    res_next.bound_x_high = sum_xh[RAW_W:1];
                    res_next.bound_y_high = sum_yh[RAW_W:1];
                    res_next.last         = 1'b1;
                    calibrating_next      = 1'b0;
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            min_samples_reg <= MIN_SAMPLES_RESET;
            win_count_reg   <= '0;
            win_sum_x_reg   <= '0;
            win_sum_y_reg   <= '0;
            calibrating_reg <= 1'b0;
            step_reg        <= STEP_DONE;
            cal_count_reg   <= '0;
            cal_sum_x_reg   <= '0;
            cal_sum_y_reg   <= '0;
            for (int i = 0; i < 4; i++)
            begin
                corner_x_reg[i] <= '0;
                corner_y_reg[i] <= '0;
            end
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            min_samples_reg <= min_samples_next;
            win_count_reg   <= win_count_next;
            win_sum_x_reg   <= win_sum_x_next;
            win_sum_y_reg   <= win_sum_y_next;
            calibrating_reg <= calibrating_next;
            step_reg        <= step_next;
            cal_count_reg   <= cal_count_next;
            cal_sum_x_reg   <= cal_sum_x_next;
            cal_sum_y_reg   <= cal_sum_y_next;
            corner_x_reg    <= corner_x_next;
            corner_y_reg    <= corner_y_next;
            res_valid_reg   <= res_valid_next;
        end
    end

endmodule

/* rtl/touch_sample_averager_with_calibration_core.sv */
// Top level of the touch sample averager with four-corner calibration.
//
//  channel   dir  tdata                                      tuser
//  s_axis    in   raw_x, raw_y                               operation, pen_released
//  m_axis    out  cal_step, avg_x, avg_y, bounds (x/y lo/hi) result_kind; tlast = last
//  cfg       in   cfg_wdata = min_samples, written when cfg_we
//
// A pen sample is added to the window from idle. A tick on a long enough window starts both
// restoring dividers, then emits the average once the result register is free; if that fills
// a corner's calibration set, it divides again and emits the corner. A tick on a short window
// only clears it; a start or an advance in calibration emits a step, at done a finish. The
// two-entry queue takes beats until full while the back end divides or the result register
// waits on m_axis_tready. Reset empties queue and sums, sets min_samples to 6, step to done.
module touch_sample_averager_with_calibration_core
    import tsac_pkg::*;
#(
    parameter int unsigned MAX_SAMPLES = 32,
    parameter int unsigned CAL_SAMPLES = 16,
    parameter int unsigned ADC_MAX     = 4095
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [31:0]      s_axis_tdata,  // raw_x, raw_y
    input  logic [2:0]       s_axis_tuser,  // operation, pen_released
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [103:0]     m_axis_tdata,  // cal_step, avg_x, avg_y, bound_x_low,
                                            // bound_y_low, bound_x_high, bound_y_high
    output logic [1:0]       m_axis_tuser,  // result_kind
    output logic             m_axis_tlast
);

    logic    q_full;
    logic    q_push;
    cmd_t    q_in;
    logic    q_pop;
    logic    q_valid;
    cmd_t    q_out;
    result_t res;

    tsac_front #(
        .ADC_MAX (ADC_MAX)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (q_in)
    );

    tsac_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_cmd  (q_out)
    );

    tsac_back #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_cmd     (q_out),
        .q_pop     (q_pop),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {5'd0, res.bound_y_high, res.bound_x_high, res.bound_y_low,
                           res.bound_x_low, res.avg_y, res.avg_x, res.cal_step};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

endmodule
